/* design/bvh_ray_leaf_hit_counter_top_assert.svh */
// ---------------------------------------------------------------------------
// BVH leaf-hit counter assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef BVH_RAY_LEAF_HIT_COUNTER_TOP_ASSERT_SVH
`define BVH_RAY_LEAF_HIT_COUNTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define BLH_ASSERT_IMPL(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define BLH_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define BLH_ASSERT_IMPL(lbl, a, c)
`define BLH_ASSERT_NEXT(lbl, a, c)
`endif
`endif

/* design/blh_pkg.sv */
// ---------------------------------------------------------------------------
// BVH leaf-hit counter package
// Shared types and constants.
// ---------------------------------------------------------------------------
`default_nettype none
package blh_pkg;
    localparam int CMD_LOAD  = 0;
    localparam int CMD_TRACE = 1;
    localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;
    localparam logic [12:0] HITS_MAX = 13'h1fff;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RECIP, ST_FETCH, ST_WAIT, ST_MUL, ST_CMP, ST_POP,
        ST_POPWAIT, ST_DONE
    } blh_state_t;

    // saturate a 64-bit signed value to 32 bits
    function automatic logic [31:0] sat64(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647) r = S32_MAX;
        else if (v < -64'sd2147483648) r = S32_MIN;
        else r = v[31:0];
        return r;
    endfunction
endpackage
`default_nettype wire

/* design/blh_divider.sv */
// ---------------------------------------------------------------------------
// BVH reciprocal divider
// Radix-2 restoring divide of 2^(2F) by a signed divisor, one bit a cycle,
// truncated toward zero and saturated; zero divisor gives the positive max.
// ---------------------------------------------------------------------------
`default_nettype none
module blh_divider
    import blh_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);
    localparam int NB = 2 * FRAC_BITS + 1;
    localparam int CW = $clog2(NB + 1);

    logic [NB-1:0] q_reg, q_next;
    logic [32:0]   rem_reg, rem_next;
    logic [31:0]   dabs_reg;
    logic          neg_reg, zero_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [33:0]   trial;
    logic [32:0]   shl;
    logic signed [63:0] sq;

    always_comb
    begin
        shl      = {rem_reg[31:0], q_reg[NB-1]};
        trial    = {1'b0, shl} - {2'b0, dabs_reg};
        rem_next = trial[33] ? shl : trial[32:0];
        q_next   = {q_reg[NB-2:0], ~trial[33]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NB);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg    <= NB'(1) << (2 * FRAC_BITS);
            rem_reg  <= '0;
            dabs_reg <= divisor[31] ? (~divisor + 1'b1) : divisor;
            neg_reg  <= divisor[31];
            zero_reg <= (divisor == '0);
        end
        else if (busy_reg)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    always_comb
    begin
        sq = neg_reg ? -$signed(64'(q_reg)) : $signed(64'(q_reg));
        quotient = zero_reg ? S32_MAX : sat64(sq);
    end
endmodule
`default_nettype wire

/* design/blh_node_mem.sv */
// ---------------------------------------------------------------------------
// BVH node memory
// One synchronous RAM of node records, one write and one read port.
// ---------------------------------------------------------------------------
`default_nettype none
module blh_node_mem #(
    parameter int NODE_COUNT = 4096,
    parameter int AW = 12,
    parameter int DW = 216
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);
    logic [DW-1:0] mem [NODE_COUNT];

    always_ff @(posedge clk)
    begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* design/bvh_ray_leaf_hit_counter_top.sv */
// ---------------------------------------------------------------------------
// BVH ray leaf-hit counter
// Walks a stored BVH with a ray and counts the leaves whose boxes it reaches.
// ---------------------------------------------------------------------------
// Usage:
//  s_axis carries requests. tuser = command (0 load node, 1 trace ray).
//  A load writes one node record and gives no result.
//  A trace gives one m_axis result: leaf hit count and stack overflow flag.
//  A trace first runs three serial reciprocal divides (one quotient bit a
//  cycle), then visits nodes: a node memory read, six slab multiplies
//  through one shared 32x32 multiplier, and a compare; a node reached by a
//  pop first passes through an extra state for the stack read.
//  Node visits per ray follow the tree, capped at NODE_COUNT.
//  Only one request is in the block at a time; s_axis_tready is low during
//  a trace. The result sits in an output register until m_axis_tready;
//  the next request is taken while the result waits if it is a load,
//  a trace waits for the output register to drain.
//  Reset clears control only; node and stack memories hold garbage until
//  written, there is no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none
`include "bvh_ray_leaf_hit_counter_top_assert.svh"
module bvh_ray_leaf_hit_counter_top
    import blh_pkg::*;
#(
    parameter int NODE_COUNT  = 4096,
    parameter int STACK_DEPTH = 64,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: node_index[11:0], first_x,y,z, second_x,y,z, left_child, right_child
    input  wire logic [231:0] s_axis_tdata,
    // tuser: command
    input  wire logic         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: leaf_hits[12:0], stack_overflowed[13], zero pad
    output logic [15:0]       m_axis_tdata
);
    localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam int VW = $clog2(NODE_COUNT + 1);
    localparam int DW = 216;
    localparam logic signed [31:0] TMIN = 32'(((1 << FRAC_BITS) + 500) / 1000);

    // request fields
    logic [11:0] f_index, f_left, f_right;
    logic [31:0] f_first [3];
    logic [31:0] f_second [3];
    assign f_index     = s_axis_tdata[11:0];
    assign f_first[0]  = s_axis_tdata[43:12];
    assign f_first[1]  = s_axis_tdata[75:44];
    assign f_first[2]  = s_axis_tdata[107:76];
    assign f_second[0] = s_axis_tdata[139:108];
    assign f_second[1] = s_axis_tdata[171:140];
    assign f_second[2] = s_axis_tdata[203:172];
    assign f_left      = s_axis_tdata[215:204];
    assign f_right     = s_axis_tdata[227:216];

    blh_state_t state_reg, state_next;
    logic        accept, is_load, is_trace;
    logic [31:0] org_reg [3];
    logic [31:0] dir_reg [3];
    logic [31:0] rc_reg  [3];
    logic [1:0]  ax_reg;
    logic [2:0]  mi_reg;
    logic [31:0] t_reg [6];
    logic [AW-1:0] cur_reg;
    logic [LW-1:0] lvl_reg;
    logic [VW-1:0] vis_reg;
    logic [12:0]   hits_reg;
    logic          ovf_reg;
    logic [DW-1:0] nrd;
    logic [DW-1:0] node_reg;
    logic          div_start, div_done;
    logic [31:0]   div_q;
    logic [11:0]   stk [STACK_DEPTH];
    logic [11:0]   stk_rd;

    assign s_axis_tready = (state_reg == ST_IDLE) &&
                           (!m_axis_tvalid || !s_axis_tuser);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign is_load  = accept && (s_axis_tuser == 1'(CMD_LOAD));
    assign is_trace = accept && (s_axis_tuser == 1'(CMD_TRACE));

    logic [AW-1:0] raddr;
    logic [DW-1:0] wdata;
    assign wdata = {f_right, f_left, f_second[2], f_second[1], f_second[0],
                    f_first[2], f_first[1], f_first[0]};

    blh_node_mem #(.NODE_COUNT(NODE_COUNT), .AW(AW), .DW(DW)) u_mem (
        .clk(clk), .we(is_load), .waddr(f_index[AW-1:0]), .wdata(wdata),
        .raddr(raddr), .rdata(nrd)
    );

    blh_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .divisor(dir_reg[ax_reg]),
        .done(div_done), .quotient(div_q)
    );

    // node fields; slab term t_sel is worked on while mi_reg = t_sel + 1
    logic [31:0] corner;
    logic [11:0] n_left, n_right;
    logic [2:0]  t_sel;
    assign n_left  = node_reg[203:192];
    assign n_right = node_reg[215:204];
    assign t_sel   = mi_reg - 3'd1;
    always_comb
    begin
        case (t_sel)
            3'd0: corner = node_reg[31:0];
            3'd1: corner = node_reg[127:96];
            3'd2: corner = node_reg[63:32];
            3'd3: corner = node_reg[159:128];
            3'd4: corner = node_reg[95:64];
            default: corner = node_reg[191:160];
        endcase
    end

    // one slab term per cycle: diff, multiply, floor shift, saturate
    logic [1:0] mi_ax;
    logic signed [31:0] diff;
    logic signed [63:0] prod, shp;
    assign mi_ax = t_sel[2:1];
    always_comb
    begin
        diff = $signed(sat64($signed(64'($signed(corner))) -
                             $signed(64'($signed(org_reg[mi_ax])))));
        prod = diff * $signed(rc_reg[mi_ax]);
        shp  = prod >>> FRAC_BITS;
    end

    // box decision
    logic signed [31:0] lo [3];
    logic signed [31:0] hi [3];
    logic signed [31:0] tn, tf;
    logic hit;
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if ($signed(t_reg[2*i]) > $signed(t_reg[2*i+1]))
            begin
                lo[i] = t_reg[2*i+1]; hi[i] = t_reg[2*i];
            end
            else
            begin
                lo[i] = t_reg[2*i]; hi[i] = t_reg[2*i+1];
            end
        end
        tn = lo[0];
        if (lo[1] > tn) tn = lo[1];
        if (lo[2] > tn) tn = lo[2];
        tf = hi[0];
        if (hi[1] < tf) tf = hi[1];
        if (hi[2] < tf) tf = hi[2];
        hit = !(tf < tn || tf < TMIN);
    end

    always_ff @(posedge clk)
    begin
        stk_rd <= stk[SW'(lvl_reg - 1'b1)];
        if (state_reg == ST_CMP && hit && n_left != n_right &&
            lvl_reg < LW'(STACK_DEPTH))
            stk[lvl_reg[SW-1:0]] <= n_right;
    end

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        raddr      = cur_reg;
        case (state_reg)
            ST_IDLE:    if (is_trace) state_next = ST_RECIP;
            ST_RECIP:   begin div_start = 1'b1; state_next = ST_WAIT; end
            ST_WAIT:    if (div_done)
                            state_next = (ax_reg == 2'd2) ? ST_FETCH : ST_RECIP;
            ST_FETCH:   state_next = ST_MUL;
            ST_MUL:     if (mi_reg == 3'd6) state_next = ST_CMP;
            ST_CMP:
            begin
                if (hit && n_left != n_right)
                    state_next = (vis_reg >= VW'(NODE_COUNT)) ? ST_DONE : ST_FETCH;
                else if (lvl_reg == '0 || vis_reg >= VW'(NODE_COUNT))
                    state_next = ST_DONE;
                else
                    state_next = ST_POP;
                raddr = n_left[AW-1:0];
            end
            ST_POP:     state_next = ST_POPWAIT;
            ST_POPWAIT: begin raddr = stk_rd[AW-1:0]; state_next = ST_MUL; end
            ST_DONE:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            m_axis_tvalid <= 1'b0;
            lvl_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
            if (state_reg == ST_DONE) m_axis_tvalid <= 1'b1;
            if (is_trace) lvl_reg <= '0;
            if (state_reg == ST_CMP && hit && n_left != n_right &&
                lvl_reg < LW'(STACK_DEPTH))
                lvl_reg <= lvl_reg + 1'b1;
            if (state_reg == ST_POP) lvl_reg <= lvl_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (is_trace)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        org_reg[i] <= f_first[i];
                        dir_reg[i] <= f_second[i];
                    end
                    ax_reg   <= 2'd0;
                    hits_reg <= '0;
                    ovf_reg  <= 1'b0;
                    vis_reg  <= '0;
                    cur_reg  <= '0;
                end
            ST_WAIT:
                if (div_done)
                begin
                    rc_reg[ax_reg] <= div_q;
                    ax_reg <= ax_reg + 1'b1;
                end
            ST_FETCH:
            begin
                mi_reg  <= '0;
                vis_reg <= vis_reg + 1'b1;
            end
            ST_MUL:
            begin
                if (mi_reg == '0) node_reg <= nrd;
                else
                begin
                    t_reg[t_sel] <= sat64(shp);
                end
                mi_reg <= mi_reg + 1'b1;
            end
            ST_CMP:
            begin
                t_reg[5] <= t_reg[5];
                if (hit && n_left == n_right && hits_reg != HITS_MAX)
                    hits_reg <= hits_reg + 1'b1;
                if (hit && n_left != n_right)
                begin
                    if (lvl_reg >= LW'(STACK_DEPTH)) ovf_reg <= 1'b1;
                    cur_reg <= n_left[AW-1:0];
                end
            end
            ST_POPWAIT:
            begin
                cur_reg <= stk_rd[AW-1:0];
                mi_reg  <= '0;
                vis_reg <= vis_reg + 1'b1;
            end
            ST_DONE:
                m_axis_tdata <= {2'b00, ovf_reg, hits_reg};
            default: ;
        endcase
    end

    `BLH_ASSERT_IMPL(a_ready_idle, s_axis_tready, state_reg == ST_IDLE)
    `BLH_ASSERT_IMPL(a_lvl_bound, 1'b1, lvl_reg <= LW'(STACK_DEPTH))
    `BLH_ASSERT_NEXT(a_done_valid, state_reg == ST_DONE, m_axis_tvalid)
endmodule
`default_nettype wire

/* bench/tb_top.sv */
// ---------------------------------------------------------------------------
// BVH leaf-hit counter testbench
// Loads small trees of nodes, traces rays through them and checks each
// result (leaf count and overflow flag) against a built-in walker.
// ---------------------------------------------------------------------------
module tb_top;
    import blh_pkg::*;

    localparam int  NODES      = 4096;
    localparam int  DEPTH      = 64;
    localparam int  FRAC       = 16;
    localparam longint TMIN    = ((longint'(1) << FRAC) + 500) / 1000;
    localparam longint SMAX    = 64'sd2147483647;
    localparam longint SMIN    = -64'sd2147483648;
    localparam int  WATCHDOG   = 200000;
    localparam int  HOLD_CYCLES = 400;

    typedef struct {
        bit                 cmd;
        logic [11:0]        idx;
        logic signed [31:0] a [3];
        logic signed [31:0] b [3];
        logic [11:0]        lft;
        logic [11:0]        rgt;
    } request_t;

    typedef struct {
        logic [12:0] hits;
        logic        ovf;
    } tally_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [231:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [15:0]  m_axis_tdata;

    bvh_ray_leaf_hit_counter_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // mirror of the node store and the traversal stack
    logic signed [31:0] box_lo [3][NODES];
    logic signed [31:0] box_hi [3][NODES];
    logic [11:0]        kid_l [NODES];
    logic [11:0]        kid_r [NODES];
    logic [11:0]        pend_stack [DEPTH];

    request_t pending_reqs [$];
    tally_t   expected_tallies [$];
    int       mismatches = 0;
    int       tallies_seen = 0;
    int       idle_cycles = 0;
    bit       s_fire = 1'b0;
    bit       m_fire = 1'b0;
    bit       quiet = 1'b0;
    int       tx_gap = 0;
    int       rx_gap = 0;
    int       rx_hold = 0;
    bit       hold_done = 1'b0;

    function automatic longint clamp32(longint v);
        if (v > SMAX) return SMAX;
        if (v < SMIN) return SMIN;
        return v;
    endfunction

    function automatic longint inv_dir(logic signed [31:0] d);
        if (d == 0) return SMAX;
        return clamp32((longint'(1) << (2 * FRAC)) / longint'(d));
    endfunction

    function automatic longint slab_dist(longint corner, longint org, longint rc);
        longint diff;
        diff = clamp32(corner - org);
        return clamp32((diff * rc) >>> FRAC);
    endfunction

    function automatic bit ray_hits_box(int n, longint org [3], longint rc [3]);
        longint ta, tb, tnear, tfar, tmp;
        tnear = SMIN;
        tfar  = SMAX;
        for (int k = 0; k < 3; k++)
        begin
            ta = slab_dist(longint'(box_lo[k][n]), org[k], rc[k]);
            tb = slab_dist(longint'(box_hi[k][n]), org[k], rc[k]);
            if (ta > tb)
            begin
                tmp = ta;
                ta = tb;
                tb = tmp;
            end
            if (ta > tnear) tnear = ta;
            if (tb < tfar) tfar = tb;
        end
        return !(tfar < tnear || tfar < TMIN);
    endfunction

    // walk the tree from the root; count leaves, flag dropped pushes
    function automatic tally_t count_leaf_hits(request_t rq);
        longint org [3];
        longint rc [3];
        int     cur, level, visits;
        bit     down;
        tally_t t;
        t.hits = '0;
        t.ovf  = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            org[k] = longint'(rq.a[k]);
            rc[k]  = inv_dir(rq.b[k]);
        end
        level  = 0;
        cur    = 0;
        visits = 0;
        forever
        begin
            down = 1'b0;
            if (visits >= NODES) break;
            visits++;
            if (ray_hits_box(cur, org, rc))
            begin
                if (kid_l[cur] == kid_r[cur])
                begin
                    if (t.hits != HITS_MAX) t.hits++;
                end
                else
                begin
                    if (level < DEPTH)
                    begin
                        pend_stack[level] = kid_r[cur];
                        level++;
                    end
                    else
                        t.ovf = 1'b1;
                    cur  = kid_l[cur];
                    down = 1'b1;
                end
            end
            if (down) continue;
            if (level == 0) break;
            level--;
            cur = pend_stack[level];
        end
        return t;
    endfunction

    function automatic void store_node(request_t rq);
        for (int k = 0; k < 3; k++)
        begin
            box_lo[k][rq.idx] = rq.a[k];
            box_hi[k][rq.idx] = rq.b[k];
        end
        kid_l[rq.idx] = rq.lft;
        kid_r[rq.idx] = rq.rgt;
    endfunction

    // ---- stimulus builders ----
    task automatic queue_node(int idx, logic signed [31:0] lo [3], logic signed [31:0] hi [3],
                              int l, int r);
        request_t rq;
        rq.cmd = 1'(CMD_LOAD);
        rq.idx = 12'(idx);
        rq.a   = lo;
        rq.b   = hi;
        rq.lft = 12'(l);
        rq.rgt = 12'(r);
        pending_reqs.insert(pending_reqs.size(), rq);
    endtask

    task automatic queue_ray(logic signed [31:0] o [3], logic signed [31:0] d [3]);
        request_t rq;
        rq.cmd = 1'(CMD_TRACE);
        rq.idx = 12'($urandom);
        rq.a   = o;
        rq.b   = d;
        rq.lft = 12'($urandom);
        rq.rgt = 12'($urandom);
        pending_reqs.insert(pending_reqs.size(), rq);
    endtask

    // coordinate near the origin with random fraction bits
    function automatic logic signed [31:0] near_val(int lo_i, int hi_i);
        return ($signed($urandom_range(0, hi_i - lo_i)) + lo_i) * 65536
               + $signed($urandom_range(0, 65535));
    endfunction

    task automatic random_box(output logic signed [31:0] lo [3],
                              output logic signed [31:0] hi [3]);
        bit wild;
        wild = ($urandom_range(0, 9) < 2);
        for (int k = 0; k < 3; k++)
        begin
            if (wild)
            begin
                lo[k] = $urandom;
                hi[k] = $urandom;
            end
            else
            begin
                lo[k] = near_val(-40, 2);
                hi[k] = near_val(-2, 40);
            end
        end
    endtask

    task automatic random_ray(output logic signed [31:0] o [3],
                              output logic signed [31:0] d [3]);
        int mode;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < 3; k++)
        begin
            o[k] = (mode == 0) ? $signed($urandom) : near_val(-10, 10);
            case ($urandom_range(0, 9))
                0: d[k] = 0;
                1: d[k] = $urandom;
                2: d[k] = $signed($urandom_range(0, 255)) - 128;
                default: d[k] = near_val(-4, 4);
            endcase
        end
    endtask

    // heap-shaped tree on random slots, root at slot 0, then a few rays
    task automatic queue_tree_phase(int size, int rays);
        int slots [];
        logic signed [31:0] lo [3];
        logic signed [31:0] hi [3];
        logic signed [31:0] o [3];
        logic signed [31:0] d [3];
        int leaf_kid;
        bit dup;
        slots = new[size];
        slots[0] = 0;
        for (int i = 1; i < size; i++)
        begin
            do
            begin
                slots[i] = $urandom_range(1, NODES - 1);
                dup = 1'b0;
                for (int j = 1; j < i; j++)
                    if (slots[j] == slots[i]) dup = 1'b1;
            end while (dup);
        end
        for (int i = size - 1; i >= 0; i--)
        begin
            random_box(lo, hi);
            if (2 * i + 2 < size)
                queue_node(slots[i], lo, hi, slots[2 * i + 1], slots[2 * i + 2]);
            else
            begin
                leaf_kid = $urandom_range(0, NODES - 1);
                queue_node(slots[i], lo, hi, leaf_kid, leaf_kid);
            end
        end
        for (int i = 0; i < rays; i++)
        begin
            random_ray(o, d);
            queue_ray(o, d);
        end
    endtask

    task automatic build_stimulus();
        logic signed [31:0] lo [3];
        logic signed [31:0] hi [3];
        logic signed [31:0] o [3];
        logic signed [31:0] d [3];
        // root with two leaf children; boxes straddle the origin
        lo = '{-32'sd655360, -32'sd655360, -32'sd655360};
        hi = '{32'sd655360, 32'sd655360, 32'sd655360};
        queue_node(0, lo, hi, 4094, 4095);
        queue_node(4094, lo, hi, 0, 0);
        lo = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
        hi = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff};
        queue_node(4095, lo, hi, 4095, 4095);
        // zero direction on every axis and on single axes, then extreme directions
        o = '{0, 0, 0};
        d = '{0, 0, 0};
        queue_ray(o, d);
        d = '{0, 32'sd65536, 32'sd65536};
        queue_ray(o, d);
        d = '{32'sd1, -32'sd1, 32'sd0};
        queue_ray(o, d);
        d = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sd65536};
        queue_ray(o, d);
        // extreme origins, outside the root box
        o = '{32'sh7fff_ffff, 32'sh8000_0000, 0};
        d = '{-32'sd65536, 32'sd65536, 32'sd1};
        queue_ray(o, d);
        o = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
        d = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000};
        queue_ray(o, d);
        // box behind the ray: tfar below the minimum distance
        o = '{32'sd1310720, 0, 0};
        d = '{32'sd65536, 0, 0};
        queue_ray(o, d);
        // cyclic root: left child is itself, so the walk hits the visit cap
        // and the stack overflows on the way
        lo = '{-32'sd655360, -32'sd655360, -32'sd655360};
        hi = '{32'sd655360, 32'sd655360, 32'sd655360};
        queue_node(0, lo, hi, 0, 4094);
        o = '{0, 0, 0};
        d = '{32'sd65536, 32'sd65536, 32'sd65536};
        queue_ray(o, d);
        // root that is itself a leaf
        queue_node(0, lo, hi, 7, 7);
        queue_ray(o, d);
        while (pending_reqs.size() < 730)
            queue_tree_phase($urandom_range(1, 15), $urandom_range(2, 8));
        // one deep tree to exercise deeper stacks
        queue_tree_phase(63, 4);
    endtask

    // ---- sender: drive requests at the falling edge ----
    always @(negedge clk)
    begin
        request_t rq;
        if (rst_n)
        begin
            if (s_axis_tvalid && !s_fire)
                ; // hold the offered request until it is taken
            else if (tx_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                tx_gap--;
            end
            else if (pending_reqs.size() > 0)
            begin
                rq = pending_reqs[0];
                pending_reqs.delete(0);
                s_axis_tuser  <= rq.cmd;
                s_axis_tdata  <= {4'b0, rq.rgt, rq.lft, rq.b[2], rq.b[1], rq.b[0],
                                  rq.a[2], rq.a[1], rq.a[0], rq.idx};
                s_axis_tvalid <= 1'b1;
                if (pending_reqs.size() % 100 == 0) quiet = ($urandom_range(0, 1) == 1);
                tx_gap = quiet ? 0 : $urandom_range(0, 19);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // ---- receiver: random stalls plus one long hold-off ----
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (m_fire) rx_gap = quiet ? 0 : $urandom_range(0, 19);
            if (!hold_done && tallies_seen >= 20)
            begin
                rx_hold   = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (rx_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_hold--;
            end
            else if (rx_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_gap--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ---- monitor: predict on accepted requests, check results ----
    always @(posedge clk)
    begin
        request_t rq;
        tally_t   want;
        s_fire <= s_axis_tvalid && s_axis_tready;
        m_fire <= m_axis_tvalid && m_axis_tready;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                rq.cmd = s_axis_tuser;
                rq.idx = s_axis_tdata[11:0];
                for (int k = 0; k < 3; k++)
                begin
                    rq.a[k] = s_axis_tdata[12 + 32 * k +: 32];
                    rq.b[k] = s_axis_tdata[108 + 32 * k +: 32];
                end
                rq.lft = s_axis_tdata[215:204];
                rq.rgt = s_axis_tdata[227:216];
                if (rq.cmd == CMD_LOAD)
                    store_node(rq);
                else
                    expected_tallies.insert(expected_tallies.size(), count_leaf_hits(rq));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                tallies_seen++;
                if (expected_tallies.size() == 0)
                begin
                    $error("unexpected result %h", m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_tallies[0];
                    expected_tallies.delete(0);
                    if (m_axis_tdata[12:0] !== want.hits)
                    begin
                        $error("leaf_hits: expected %0d, got %0d", want.hits,
                               m_axis_tdata[12:0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[13] !== want.ovf)
                    begin
                        $error("stack_overflowed: expected %0d, got %0d", want.ovf,
                               m_axis_tdata[13]);
                        mismatches++;
                    end
                end
            end
            // advance the watchdog only while nothing moves
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= WATCHDOG)
            begin
                $display("Some tests failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        build_stimulus();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // drain: all requests taken and every result back
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_tallies.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (expected_tallies.size() > 0)
        begin
            $error("%0d results never arrived", expected_tallies.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+design
design/blh_pkg.sv
design/blh_divider.sv
design/blh_node_mem.sv
design/bvh_ray_leaf_hit_counter_top.sv
bench/tb_top.sv
